/* hdl/pfa_pkg.sv */
// Package for the prime field arithmetic unit: widths, operation codes,
// the exponent sequencer states and queue sizing. No dependencies.
package pfa_pkg;

  localparam int W          = 16;                 // operand / modulus width
  localparam int CMD_W      = 2;
  localparam int ITEM_W     = CMD_W + 2 * W;      // queued request
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int MU_W       = 2 * W;              // Barrett reciprocal width
  localparam int MU_STEPS   = 2 * W + 1;          // quotient bits of 2^(2W)/p
  localparam int MU_CW      = $clog2(MU_STEPS);
  localparam int BIT_CW     = $clog2(W);
  localparam int MM_LAT     = 4;                  // modmul pipeline depth

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_SQR_GO,
    EX_SQR_WT,
    EX_MUL_GO,
    EX_MUL_WT,
    EX_DONE
  } ex_state_t;

endpackage

/* hdl/pfa_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/pfa_modmul.sv */
// Pipelined modular multiplier (x*y mod p) using Barrett reduction with a
// precomputed reciprocal mu = floor(2^(2W)/p). Depends on pfa_pkg.
module pfa_modmul (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic [pfa_pkg::W-1:0]   x,
  input  logic [pfa_pkg::W-1:0]   y,
  input  logic [pfa_pkg::W-1:0]   p,
  input  logic [pfa_pkg::MU_W-1:0] mu,
  output logic                    out_vld,
  output logic [pfa_pkg::W-1:0]   res
);
  import pfa_pkg::*;

  logic [MM_LAT-1:0] vld_r;
  logic [2*W-1:0]    prod_r;
  logic [2*W-1:0]    prod2_r;
  logic [2*W-1:0]    q_r;
  logic [W:0]        rem_r;
  logic [W-1:0]      res_r;
  logic [4*W-1:0]    qm;
  logic [2*W-1:0]    qp;
  logic [2*W-1:0]    diff;

  assign qm   = {{(2*W){1'b0}}, prod_r} * {{(4*W-MU_W){1'b0}}, mu};
  assign qp   = q_r * {{W{1'b0}}, p};
  assign diff = prod2_r - qp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[MM_LAT-2:0], in_vld};
    end
  end

  // quotient estimate is at most one short, so the remainder stays below 2p
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= {{W{1'b0}}, x} * {{W{1'b0}}, y};
      prod2_r <= prod_r;
      q_r     <= qm[4*W-1:2*W];
      rem_r   <= diff[W:0];
      res_r   <= (rem_r >= {1'b0, p}) ? W'(rem_r - {1'b0, p}) : rem_r[W-1:0];
    end
  end

  assign out_vld = vld_r[MM_LAT-1];
  assign res     = res_r;

endmodule

/* hdl/prime_field_arith_unit_top.sv */
// Top level of the prime field arithmetic unit. Depends on pfa_pkg,
// pfa_ram (request queue) and pfa_modmul (Barrett multipliers).
//
// Usage: requests enter on in_* (in_tuser = operation, in_tdata = operands),
// results leave on out_* one per request, in request order. The modulus is
// written on cfg_we/cfg_wdata while the unit is idle; a write of a modulus of
// two or more starts a computation of the Barrett reciprocal during which the
// engine holds (requests are still queued).
// Requests land in a 16-entry queue held in RAM, so in_tready depends only
// on queue space, never on out_tready.
// Add, subtract and multiply: one request per cycle while the engine does not
// hold, through queue read, 4-stage operand reduction, 4-stage multiply (or
// bypass line for add and subtract) and output register.
// Divide with nonzero operands: the inverse b^(p-2) is formed by a
// square-and-multiply sequencer on its own 4-stage multiplier, with
// 16 squarings plus one step per set bit of p-2, while the engine behind
// it holds.
// Reset: modulus 2, queue empty, output invalid.
// A stalled receiver holds the result in the output register; the engine
// stops and the queue keeps accepting until it is full.
module prime_field_arith_unit_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [2*pfa_pkg::W-1:0]    in_tdata,   // operand_a, operand_b
  input  logic [pfa_pkg::CMD_W-1:0]  in_tuser,   // command
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [pfa_pkg::W-1:0]      out_tdata,  // field_result
  input  logic                       cfg_we,
  input  logic [pfa_pkg::W-1:0]      cfg_wdata   // field_prime
);
  import pfa_pkg::*;

  // configuration and reciprocal
  logic [W-1:0]      p_r;
  logic [MU_W-1:0]   mu_r;
  logic              mu_busy_r;
  logic [MU_CW-1:0]  mu_cnt_r;
  logic [W-1:0]      mu_rem_r;
  logic [W:0]        mu_t;
  logic              mu_ge;
  logic              p_small;
  logic [W-1:0]      e_val;

  // queue
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               push, pop, adv;
  logic [ITEM_W-1:0]  fifo_q;
  logic               f_vld_r;
  logic [CMD_W-1:0]   f_cmd;
  logic [W-1:0]       f_a, f_b;

  // reduction stage
  logic [CMD_W-1:0]   cmd_pipe_r [MM_LAT];
  logic               a_vld, b_vld, r_vld;
  logic [W-1:0]       ar, br;
  cmd_t               r_cmd;

  // combine
  logic [W:0]         sum, diff;
  logic [W-1:0]       byp_val;
  logic               use_c;
  logic [W-1:0]       cx, cy;
  logic               div_needed, div_hold;
  logic               bv_r   [MM_LAT];
  logic [W-1:0]       bval_r [MM_LAT];
  logic               c_vld;
  logic [W-1:0]       c_res;
  logic               out_tvalid_r;
  logic [W-1:0]       out_tdata_r;

  // exponent sequencer
  ex_state_t          ex_st_r, ex_nxt;
  logic [W-1:0]       acc_r;
  logic [BIT_CW-1:0]  bit_r;
  logic               d_issue, d_vld;
  logic [W-1:0]       d_y, d_res;

  assign p_small = (p_r < W'(2));
  assign e_val   = p_r - W'(2);

  // ---------------- modulus and reciprocal (restoring division) ----------
  assign mu_t  = {mu_rem_r, (mu_cnt_r == MU_CW'(MU_STEPS - 1))};
  assign mu_ge = (mu_t >= {1'b0, p_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r       <= W'(2);
      mu_r      <= {1'b1, {(MU_W-1){1'b0}}};
      mu_busy_r <= 1'b0;
      mu_cnt_r  <= '0;
      mu_rem_r  <= '0;
    end else if (cfg_we) begin
      p_r       <= cfg_wdata;
      mu_busy_r <= (cfg_wdata >= W'(2));
      mu_cnt_r  <= MU_CW'(MU_STEPS - 1);
      mu_rem_r  <= '0;
      mu_r      <= '0;
    end else if (mu_busy_r) begin
      mu_rem_r <= mu_ge ? W'(mu_t - {1'b0, p_r}) : mu_t[W-1:0];
      mu_r     <= {mu_r[MU_W-2:0], mu_ge};
      if (mu_cnt_r == '0) begin
        mu_busy_r <= 1'b0;
      end else begin
        mu_cnt_r <= mu_cnt_r - MU_CW'(1);
      end
    end
  end

  // ---------------- request queue ----------------------------------------
  assign in_tready = (cnt_r != (FIFO_AW+1)'(FIFO_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign adv       = !mu_busy_r && !div_hold && (!out_tvalid_r || out_tready);
  assign pop       = adv && (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      f_vld_r  <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (FIFO_AW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (FIFO_AW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
      if (adv) begin
        f_vld_r <= pop;
      end
    end
  end

  pfa_ram #(
    .WIDTH (ITEM_W),
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (wr_ptr_r),
    .wr_data ({in_tdata, in_tuser}),
    .rd_en   (pop),
    .rd_addr (rd_ptr_r),
    .rd_data (fifo_q)
  );

  assign f_cmd = fifo_q[CMD_W-1:0];
  assign f_a   = fifo_q[CMD_W +: W];
  assign f_b   = fifo_q[CMD_W+W +: W];

  // ---------------- operand reduction (x * 1 mod p) ----------------------
  pfa_modmul u_red_a (
    .clk (clk), .rst_n (rst_n), .en (adv), .in_vld (f_vld_r),
    .x (f_a), .y (W'(1)), .p (p_r), .mu (mu_r),
    .out_vld (a_vld), .res (ar)
  );

  pfa_modmul u_red_b (
    .clk (clk), .rst_n (rst_n), .en (adv), .in_vld (f_vld_r),
    .x (f_b), .y (W'(1)), .p (p_r), .mu (mu_r),
    .out_vld (b_vld), .res (br)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_pipe_r[0] <= f_cmd;
      for (int i = 1; i < MM_LAT; i++) begin
        cmd_pipe_r[i] <= cmd_pipe_r[i-1];
      end
    end
  end

  assign r_vld = a_vld && b_vld;
  assign r_cmd = cmd_t'(cmd_pipe_r[MM_LAT-1]);

  // ---------------- combine ----------------------------------------------
  assign div_needed = r_vld && (r_cmd == CMD_DIV) && !p_small &&
                      (ar != '0) && (br != '0);
  assign div_hold   = div_needed && (ex_st_r != EX_DONE);

  assign sum  = {1'b0, ar} + {1'b0, br};
  assign diff = {1'b0, ar} - {1'b0, br};

  always_comb begin
    byp_val = '0;
    use_c   = 1'b0;
    cx      = ar;
    cy      = br;
    case (r_cmd)
      CMD_ADD: byp_val = (sum >= {1'b0, p_r}) ? W'(sum - {1'b0, p_r}) : sum[W-1:0];
      CMD_SUB: byp_val = (ar >= br) ? diff[W-1:0] : W'(diff + {1'b0, p_r});
      CMD_MUL: use_c = 1'b1;
      CMD_DIV: begin
        use_c = (ar != '0) && (br != '0);
        cy    = acc_r;
      end
      default: byp_val = '0;
    endcase
    if (p_small) begin
      use_c   = 1'b0;
      byp_val = '0;
    end
  end

  pfa_modmul u_mul (
    .clk (clk), .rst_n (rst_n), .en (adv), .in_vld (r_vld && use_c),
    .x (cx), .y (cy), .p (p_r), .mu (mu_r),
    .out_vld (c_vld), .res (c_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MM_LAT; i++) begin
        bv_r[i] <= 1'b0;
      end
    end else if (adv) begin
      bv_r[0] <= r_vld;
      for (int i = 1; i < MM_LAT; i++) begin
        bv_r[i] <= bv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bval_r[0] <= byp_val;
      for (int i = 1; i < MM_LAT; i++) begin
        bval_r[i] <= bval_r[i-1];
      end
    end
  end

  // ---------------- output register --------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= bv_r[MM_LAT-1];
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= c_vld ? c_res : bval_r[MM_LAT-1];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---------------- inverse: b^(p-2) by square-and-multiply --------------
  always_comb begin
    ex_nxt = ex_st_r;
    case (ex_st_r)
      EX_IDLE:   if (div_needed) ex_nxt = EX_SQR_GO;
      EX_SQR_GO: ex_nxt = EX_SQR_WT;
      EX_SQR_WT: begin
        if (d_vld) begin
          if (e_val[bit_r])        ex_nxt = EX_MUL_GO;
          else if (bit_r == '0)    ex_nxt = EX_DONE;
          else                     ex_nxt = EX_SQR_GO;
        end
      end
      EX_MUL_GO: ex_nxt = EX_MUL_WT;
      EX_MUL_WT: begin
        if (d_vld) begin
          ex_nxt = (bit_r == '0) ? EX_DONE : EX_SQR_GO;
        end
      end
      EX_DONE:   if (adv) ex_nxt = EX_IDLE;
      default:   ex_nxt = EX_IDLE;
    endcase
  end

  always_comb begin
    d_issue = 1'b0;
    d_y     = acc_r;
    case (ex_st_r)
      EX_SQR_GO: d_issue = 1'b1;
      EX_MUL_GO: begin
        d_issue = 1'b1;
        d_y     = br;
      end
      default:   d_issue = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_st_r <= EX_IDLE;
    end else begin
      ex_st_r <= ex_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (ex_st_r)
      EX_IDLE: begin
        acc_r <= W'(1);
        bit_r <= BIT_CW'(W - 1);
      end
      EX_SQR_WT: begin
        if (d_vld) begin
          acc_r <= d_res;
          if (!e_val[bit_r] && (bit_r != '0)) begin
            bit_r <= bit_r - BIT_CW'(1);
          end
        end
      end
      EX_MUL_WT: begin
        if (d_vld) begin
          acc_r <= d_res;
          if (bit_r != '0) begin
            bit_r <= bit_r - BIT_CW'(1);
          end
        end
      end
      default: begin
        acc_r <= acc_r;
        bit_r <= bit_r;
      end
    endcase
  end

  pfa_modmul u_exp (
    .clk (clk), .rst_n (rst_n), .en (1'b1), .in_vld (d_issue),
    .x (acc_r), .y (d_y), .p (p_r), .mu (mu_r),
    .out_vld (d_vld), .res (d_res)
  );

endmodule

/* bench/prime_field_arith_unit_top_tb.sv */
// Self-checking bench for prime_field_arith_unit_top: random and directed
// field operations over several moduli, checked against an in-bench predictor.
// Depends on pfa_pkg and the RTL of the unit.
module prime_field_arith_unit_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfa_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  class field_scoreboard;
    logic [W-1:0] pending_q[$];
    int fail_count;
    int result_count;

    function logic [W-1:0] field_compute(logic [W-1:0] modulus, cmd_t op,
                                         logic [W-1:0] a_raw, logic [W-1:0] b_raw);
      longint unsigned p, a, b, r, acc, e;
      p = 64'(modulus);
      if (p < 2) return '0;
      a = 64'(a_raw) % p;
      b = 64'(b_raw) % p;
      case (op)
        CMD_ADD: r = (a + b) % p;
        CMD_SUB: r = (a + p - b) % p;
        CMD_MUL: r = (a * b) % p;
        default: begin
          if (a == 0 || b == 0) begin
            r = 0;
          end else begin
            // Fermat inverse, scanning 16 exponent bits
            e = p - 2;
            acc = 1 % p;
            for (int i = W - 1; i >= 0; i--) begin
              acc = (acc * acc) % p;
              if (e[i]) acc = (acc * b) % p;
            end
            r = (a * acc) % p;
          end
        end
      endcase
      return r[W-1:0];
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      fail_count++;
    endtask

    function void note_request(logic [W-1:0] modulus, cmd_t op,
                               logic [W-1:0] a, logic [W-1:0] b);
      pending_q.push_back(field_compute(modulus, op, a, b));
    endfunction

    task check_result(logic [W-1:0] got);
      logic [W-1:0] want;
      result_count++;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result %0d", got));
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        report($sformatf("field_result got %0d expected %0d", got, want));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [2*W-1:0] in_tdata = '0;  // operand_a, operand_b
  logic [CMD_W-1:0] in_tuser = '0; // command
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [W-1:0] out_tdata;        // field_result
  logic cfg_we = 1'b0;
  logic [W-1:0] cfg_wdata = '0;

  field_scoreboard sb = new();
  logic [W-1:0] modulus = W'(2);
  int cycle_count = 0;
  int leftover_count = 0;
  int stall_mode = 0;

  logic [W-1:0] prime_list[] = '{16'd2, 16'd3, 16'd5, 16'd7, 16'd13, 16'd251, 16'd257,
                                 16'd65521, 16'd65519, 16'd32749};

  prime_field_arith_unit_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // receiver: stall pattern changes mode every so often
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (cycle_count % 200 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 1) != 0);
      default: out_tready <= ((cycle_count % 16) < 4);
    endcase
  end

  task automatic send_request(cmd_t op, logic [W-1:0] a, logic [W-1:0] b);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(modulus, op, a, b);
  endtask

  task automatic go_idle(int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_modulus(logic [W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    modulus = value;
  endtask

  task automatic random_burst(int count);
    int left;
    int burst;
    logic [W-1:0] a, b;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && left > 0; i++) begin
        a = W'($urandom_range(0, 65535));
        b = W'($urandom_range(0, 65535));
        // often keep operands within the field, sometimes hit zero
        if ($urandom_range(0, 3) == 0 && modulus != '0) a = a % modulus;
        if ($urandom_range(0, 7) == 0) b = modulus;
        send_request(cmd_t'($urandom_range(0, 3)), a, b);
        left--;
      end
      if ($urandom_range(0, 2) == 0) go_idle(0);
      else go_idle($urandom_range(1, 12));
    end
  endtask

  initial begin
    logic [W-1:0] p;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset modulus, then extremes under a large prime
    send_request(CMD_ADD, 16'hFFFF, 16'hFFFF);
    send_request(CMD_DIV, 16'd3, 16'd1);
    drain();
    write_modulus(16'd65521);
    drain();
    send_request(CMD_ADD, 16'hFFFF, 16'hFFFE);
    send_request(CMD_SUB, 16'd0, 16'hFFFF);
    send_request(CMD_SUB, 16'd65521, 16'd1);
    send_request(CMD_MUL, 16'hFFFF, 16'hFFFF);
    send_request(CMD_MUL, 16'h5555, 16'hAAAA);
    send_request(CMD_DIV, 16'd7, 16'd0);      // divide by zero
    send_request(CMD_DIV, 16'd65521, 16'd9);  // zero dividend
    send_request(CMD_DIV, 16'd1, 16'd65520);
    send_request(CMD_DIV, 16'hFFFF, 16'h1234);
    drain();
    // modulus below two, and a composite modulus
    write_modulus(16'd0);
    drain();
    send_request(CMD_MUL, 16'd5, 16'd6);
    send_request(CMD_DIV, 16'd5, 16'd6);
    drain();
    write_modulus(16'd1);
    drain();
    send_request(CMD_ADD, 16'd5, 16'd6);
    drain();
    write_modulus(16'hFFFF);
    drain();
    send_request(CMD_DIV, 16'd10, 16'd6);
    send_request(CMD_SUB, 16'd1, 16'd2);
    drain();

    // random phases, one modulus each
    for (int ph = 0; ph < 15; ph++) begin
      if (ph < prime_list.size()) p = prime_list[ph];
      else if (ph == 12) p = 16'h8000; // composite, top bit set
      else p = W'($urandom_range(2, 65535));
      write_modulus(p);
      drain();
      random_burst(129);
      drain();
    end

    foreach (sb.pending_q[i]) leftover_count++;
    if (leftover_count != 0) begin
      sb.report($sformatf("%0d results never arrived", leftover_count));
    end
    $display("covered %0d results over 20 moduli, including 0, 1 and composites",
             sb.result_count);
    if (sb.fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/pfa_pkg.sv
hdl/pfa_ram.sv
hdl/pfa_modmul.sv
hdl/prime_field_arith_unit_top.sv
bench/prime_field_arith_unit_top_tb.sv
